// ===== src/rbb_pkg.sv =====
// rbb_pkg: shared types and constants for the RGB 5x5 box blur.
// No dependencies; used by rbb_window and rgb_box_blur_5x5.
package rbb_pkg;

    // Channel and register widths
    localparam int PIX_W        = 8;
    localparam int WIDTH_W      = 12;
    localparam int HEIGHT_W     = 13;
    localparam int CFG_DATA_W   = 13;

    // Register reset values
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // Control from the position stage to the window-sum units
    typedef struct packed {
        logic step;   // take in a new column this cycle
        logic clear;  // start of a row: drop the old columns first
    } win_ctrl_t;

endpackage

// ===== src/rbb_ram.sv =====
// rbb_ram: generic single-write, single-read RAM with registered read data.
// Read-first when both ports hit the same address. No dependencies.
module rbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage array and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/rbb_window.sv =====
// rbb_window: running window sum for one colour channel.
// Keeps one sum per window column; depends on rbb_pkg.
module rbb_window #(
    parameter int WINDOW_SIZE = 5,
    parameter int SUM_W       = 13
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  rbb_pkg::win_ctrl_t                           ctrl,
    input  logic [WINDOW_SIZE-1:0][rbb_pkg::PIX_W-1:0]   taps,
    input  logic [WINDOW_SIZE-1:0]                       tap_mask,
    output logic [SUM_W-1:0]                             win_sum
);

    localparam int COL_W = $clog2(WINDOW_SIZE * (2 ** rbb_pkg::PIX_W - 1) + 1);

    logic [COL_W-1:0] col_sum;
    logic [COL_W-1:0] col_reg  [WINDOW_SIZE];
    logic [COL_W-1:0] col_next [WINDOW_SIZE];
    logic [SUM_W-1:0] win_sum_reg;
    logic [SUM_W-1:0] win_sum_next;

    // Sum of the incoming column, out-of-image taps masked to zero
    always_comb
    begin
        col_sum = '0;
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            if (tap_mask[i])
            begin
                col_sum = col_sum + COL_W'(taps[i]);
            end
        end
    end

    // Shift the column sums and update the window total
    always_comb
    begin
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            col_next[i] = col_reg[i];
        end
        win_sum_next = win_sum_reg;
        if (ctrl.step)
        begin
            if (ctrl.clear)
            begin
                for (int i = 0; i < WINDOW_SIZE - 1; i++)
                begin
                    col_next[i] = '0;
                end
                win_sum_next = SUM_W'(col_sum);
            end
            else
            begin
                for (int i = 0; i < WINDOW_SIZE - 1; i++)
                begin
                    col_next[i] = col_reg[i + 1];
                end
                win_sum_next = win_sum_reg - SUM_W'(col_reg[0]) + SUM_W'(col_sum);
            end
            col_next[WINDOW_SIZE - 1] = col_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_SIZE; i++)
            begin
                col_reg[i] <= '0;
            end
            win_sum_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < WINDOW_SIZE; i++)
            begin
                col_reg[i] <= col_next[i];
            end
            win_sum_reg <= win_sum_next;
        end
    end

    assign win_sum = win_sum_reg;

endmodule

// ===== src/rgb_box_blur_5x5.sv =====
// rgb_box_blur_5x5: streaming 5x5 box blur over RGB pixels in raster order.
// Pipeline: line-store read and stage 1 load at the edge accepting a pixel word, then the
// window-sum update into stage 2 and the reciprocal multiply into the stage 3 result word.
// Throughput: one pixel word per cycle; ready falls only on a full, stalled pipeline.
// Reset: position, window sums and handshake state clear; registers go to 640 x 480.
// Depends on rbb_pkg, rbb_ram and rbb_window.
module rgb_box_blur_5x5 #(
    parameter int MAX_WIDTH   = 2048,
    parameter int WINDOW_SIZE = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  rbb_pkg::cfg_index_t             cfg_index,
    input  logic [rbb_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel input channel
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  logic [rbb_pkg::PIX_W-1:0]       pixel_blue,
    input  logic [rbb_pkg::PIX_W-1:0]       pixel_green,
    input  logic [rbb_pkg::PIX_W-1:0]       pixel_red,
    // result channel
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [rbb_pkg::PIX_W-1:0]       out_blue,
    output logic [rbb_pkg::PIX_W-1:0]       out_green,
    output logic [rbb_pkg::PIX_W-1:0]       out_red,
    output logic                            frame_last
);

    localparam int PIX_W      = rbb_pkg::PIX_W;
    localparam int WORD_W     = 3 * PIX_W;
    localparam int HALF       = WINDOW_SIZE / 2;
    localparam int STORE_ROWS = WINDOW_SIZE - 1;
    localparam int TAPS       = WINDOW_SIZE * WINDOW_SIZE;
    localparam int SLOT_W     = $clog2(STORE_ROWS);
    localparam int SLOTX_W    = SLOT_W + 1;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COL_W      = $clog2(MAX_WIDTH + HALF + 1);
    localparam int ROW_W      = rbb_pkg::HEIGHT_W + 1;
    localparam int SUM_W      = $clog2(TAPS * (2 ** PIX_W - 1) + 1);
    // floor(x / TAPS) as (x * RECIP) >> DIV_SHIFT, exact for every x below 2**SUM_W
    localparam int DIV_SHIFT  = SUM_W + $clog2(TAPS);
    localparam int RECIP      = (2 ** DIV_SHIFT + TAPS - 1) / TAPS;
    localparam int RECIP_W    = $clog2(RECIP + 1);
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    // configuration registers
    logic [rbb_pkg::WIDTH_W-1:0]  width_reg;
    logic [rbb_pkg::HEIGHT_W-1:0] height_reg;

    // scan position
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [31:0]       w_eff_wide;
    logic [COL_W-1:0]  w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic [COL_W-1:0]  last_col;
    logic [ROW_W-1:0]  last_row;
    logic              col_in;
    logic              store_en;
    logic              emit;
    logic              is_last;
    logic [WINDOW_SIZE-1:0] mask_next;

    logic              accept;
    logic              en1, en2, en3;
    logic [WORD_W-1:0] pix_word;
    logic [ADDR_W-1:0] ram_addr;
    logic [STORE_ROWS-1:0] ram_wr;
    logic [WORD_W-1:0] ram_rd [STORE_ROWS];

    // stage 1: pixel and tap controls, line-store read in flight
    logic                   s1_valid_reg;
    logic [WORD_W-1:0]      s1_pix_reg;
    logic [WINDOW_SIZE-1:0] s1_mask_reg;
    logic [SLOT_W-1:0]      s1_slot_reg;
    logic                   s1_emit_reg;
    logic                   s1_last_reg;
    logic                   s1_clear_reg;

    // stage 2: window sums held in the window units
    logic                   s2_valid_reg;
    logic                   s2_last_reg;
    rbb_pkg::win_ctrl_t     win_ctrl;
    logic [WINDOW_SIZE-1:0][WORD_W-1:0] tap_word;
    logic [WINDOW_SIZE-1:0][PIX_W-1:0]  taps_blue, taps_green, taps_red;
    logic [SUM_W-1:0]       sum_blue, sum_green, sum_red;

    // stage 3: result register
    logic                   result_valid_reg;
    logic [PIX_W-1:0]       out_blue_reg, out_green_reg, out_red_reg;
    logic                   frame_last_reg;
    logic [PROD_W-1:0]      prod_blue, prod_green, prod_red;

    // Handshakes: each stage moves when the one after it has room
    assign en3         = !result_valid_reg || result_ready;
    assign en2         = !s2_valid_reg || en3;
    assign en1         = !s1_valid_reg || en2;
    assign pixel_ready = en1;
    assign accept      = pixel_valid && en1;
    assign cfg_ready   = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rbb_pkg::WIDTH_W'(rbb_pkg::WIDTH_RESET);
            height_reg <= rbb_pkg::HEIGHT_W'(rbb_pkg::HEIGHT_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rbb_pkg::REG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_data[rbb_pkg::WIDTH_W-1:0];
                end
                rbb_pkg::REG_IMAGE_HEIGHT:
                begin
                    height_reg <= cfg_data[rbb_pkg::HEIGHT_W-1:0];
                end
            endcase
        end
    end

    // Effective image size: zero acts as one, width clamps to the line store
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff_wide = 32'd1;
        end
        else if ({{(32 - rbb_pkg::WIDTH_W){1'b0}}, width_reg} > MAX_WIDTH)
        begin
            w_eff_wide = 32'(MAX_WIDTH);
        end
        else
        begin
            w_eff_wide = {{(32 - rbb_pkg::WIDTH_W){1'b0}}, width_reg};
        end
        w_eff = w_eff_wide[COL_W-1:0];
        h_eff = (height_reg == '0) ? ROW_W'(1) : {1'b0, height_reg};
        last_col = w_eff + COL_W'(HALF - 1);
        last_row = h_eff + ROW_W'(HALF - 1);
    end

    // Position decode: which taps are in the image, and whether to emit
    always_comb
    begin
        logic row_ok;
        col_in   = col_reg < w_eff;
        store_en = col_in && (row_reg < h_eff);
        emit     = (col_reg >= COL_W'(HALF)) && (row_reg >= ROW_W'(HALF));
        is_last  = (col_reg == last_col) && (row_reg == last_row);
        for (int b = 0; b < WINDOW_SIZE; b++)
        begin
            if (b == 0)
            begin
                row_ok = row_reg < h_eff;
            end
            else
            begin
                row_ok = (row_reg >= ROW_W'(b)) && ((row_reg - ROW_W'(b)) < h_eff);
            end
            mask_next[b] = col_in && row_ok;
        end
    end

    // Next position over the extended raster
    always_comb
    begin
        col_next  = col_reg + COL_W'(1);
        row_next  = row_reg;
        slot_next = slot_reg;
        if (col_reg >= last_col)
        begin
            col_next = '0;
            if (row_reg >= last_row)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = row_reg + ROW_W'(1);
                slot_next = (slot_reg == SLOT_W'(STORE_ROWS - 1)) ? '0
                                                                   : slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (cfg_valid)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // Line store: one RAM per stored row, all read at the current column
    assign pix_word = {pixel_red, pixel_green, pixel_blue};
    assign ram_addr = col_reg[ADDR_W-1:0];

    for (genvar j = 0; j < STORE_ROWS; j++)
    begin : g_row
        assign ram_wr[j] = accept && store_en && (slot_reg == SLOT_W'(j));

        rbb_ram #(
            .WIDTH (WORD_W),
            .DEPTH (MAX_WIDTH)
        ) u_row_ram (
            .clk     (clk),
            .wr_en   (ram_wr[j]),
            .wr_addr (ram_addr),
            .wr_data (pix_word),
            .rd_en   (accept),
            .rd_addr (ram_addr),
            .rd_data (ram_rd[j])
        );
    end

    // Stage 1 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pix_word;
            s1_mask_reg  <= mask_next;
            s1_slot_reg  <= slot_reg;
            s1_emit_reg  <= emit;
            s1_last_reg  <= is_last;
            s1_clear_reg <= col_reg == '0;
        end
    end

    // New window column: current pixel, then older rows from the line store
    for (genvar b = 0; b < WINDOW_SIZE; b++)
    begin : g_tap
        if (b == 0)
        begin : g_cur
            assign tap_word[b] = s1_pix_reg;
        end
        else
        begin : g_old
            localparam logic [SLOTX_W-1:0] BACK_C = SLOTX_W'(b);
            localparam logic [SLOTX_W-1:0] ROWS_C = SLOTX_W'(STORE_ROWS);
            logic [SLOTX_W-1:0] slot_x;
            logic [SLOTX_W-1:0] sel_x;

            // row slot of the row b lines back, modulo the store depth
            assign slot_x = {1'b0, s1_slot_reg};
            assign sel_x  = (slot_x >= BACK_C) ? slot_x - BACK_C
                                               : slot_x + ROWS_C - BACK_C;
            assign tap_word[b] = ram_rd[sel_x[SLOT_W-1:0]];
        end
        assign taps_blue[b]  = tap_word[b][PIX_W-1:0];
        assign taps_green[b] = tap_word[b][2*PIX_W-1:PIX_W];
        assign taps_red[b]   = tap_word[b][3*PIX_W-1:2*PIX_W];
    end

    // Stage 2: window sums per channel
    assign win_ctrl.step  = s1_valid_reg && en2;
    assign win_ctrl.clear = s1_clear_reg;

    rbb_window #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SUM_W       (SUM_W)
    ) u_win_blue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (win_ctrl),
        .taps     (taps_blue),
        .tap_mask (s1_mask_reg),
        .win_sum  (sum_blue)
    );

    rbb_window #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SUM_W       (SUM_W)
    ) u_win_green (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (win_ctrl),
        .taps     (taps_green),
        .tap_mask (s1_mask_reg),
        .win_sum  (sum_green)
    );

    rbb_window #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SUM_W       (SUM_W)
    ) u_win_red (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (win_ctrl),
        .taps     (taps_red),
        .tap_mask (s1_mask_reg),
        .win_sum  (sum_red)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_last_reg <= s1_last_reg;
        end
    end

    // Stage 3: divide by the tap count through the reciprocal
    assign prod_blue  = {{RECIP_W{1'b0}}, sum_blue}  * {{SUM_W{1'b0}}, RECIP_C};
    assign prod_green = {{RECIP_W{1'b0}}, sum_green} * {{SUM_W{1'b0}}, RECIP_C};
    assign prod_red   = {{RECIP_W{1'b0}}, sum_red}   * {{SUM_W{1'b0}}, RECIP_C};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en3)
        begin
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            out_blue_reg   <= prod_blue[DIV_SHIFT +: PIX_W];
            out_green_reg  <= prod_green[DIV_SHIFT +: PIX_W];
            out_red_reg    <= prod_red[DIV_SHIFT +: PIX_W];
            frame_last_reg <= s2_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_blue     = out_blue_reg;
    assign out_green    = out_green_reg;
    assign out_red      = out_red_reg;
    assign frame_last   = frame_last_reg;

endmodule
